FILE: hdl/bbs_pkg.sv
// Shared types and constants for the Bayesian Blocks segmenter.
`default_nettype none
package bbs_pkg;
    localparam int MAX_EVENTS_DEF = 63;
    localparam int TIME_W = 32;
    localparam int EDGE_W = 33;
    localparam int PEN_W = 24;
    localparam logic [PEN_W-1:0] PEN_RESET = 24'd262144;
    localparam int FIT_W = 48;
    localparam int LOGX_W = 34;
    localparam int LN_W = 22;
    localparam int MANT_W = 31;
    localparam int FRAC_BITS = 16;
    localparam int LOGP_W = 6;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_PENALTY = 3'd0;

    typedef struct packed {
        logic load;
        logic kread;
        logic ktop;
        logic iread;
        logic wlatch;
        logic log_start;
        logic log_w;
        logic ln2c_latch;
        logic term;
        logic fit;
        logic cmp;
        logic kwr;
        logic tb_init;
        logic tb_wr;
        logic tb_load;
        logic em_tp;
        logic em_ed;
        logic out_load;
    } bbs_cmd_t;

    typedef struct packed {
        logic k_last;
        logic i_last;
        logic log_done;
        logic tb_done;
        logic em_last;
    } bbs_stat_t;
endpackage
`default_nettype wire

FILE: hdl/bbs_log.sv
// Multi-cycle natural logarithm unit, Q16 result, one squaring per cycle.
`default_nettype none
module bbs_log
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [bbs_pkg::LOGX_W-1:0] x,
    output logic                            done,
    output logic [bbs_pkg::LN_W-1:0]        ln
);
    localparam int STEP_W = 5;
    localparam int LOG2_W = bbs_pkg::LOGP_W + bbs_pkg::FRAC_BITS;
    localparam int PROD_W = LOG2_W + 32;
    localparam logic [STEP_W-1:0] STEP_MUL = STEP_W'(bbs_pkg::FRAC_BITS);
    localparam logic [STEP_W-1:0] STEP_RND = STEP_W'(bbs_pkg::FRAC_BITS + 1);

    logic                            busy_reg;
    logic                            done_reg;
    logic [STEP_W-1:0]               step_reg;
    logic [bbs_pkg::LOGP_W-1:0]      p_reg;
    logic [bbs_pkg::MANT_W-1:0]      m_reg;
    logic [bbs_pkg::FRAC_BITS-1:0]   frac_reg;
    logic [PROD_W-1:0]               prod_reg;
    logic [bbs_pkg::LN_W-1:0]        ln_reg;

    logic [bbs_pkg::LOGP_W-1:0]      p_lead;
    logic [63:0]                     norm;
    logic [2*bbs_pkg::MANT_W-1:0]    sq;
    logic [bbs_pkg::MANT_W:0]        sq_s;
    logic [PROD_W:0]                 rnd;

    always_comb
    begin
        p_lead = '0;
        for (int b = 0; b < bbs_pkg::LOGX_W; b++)
        begin
            if (x[b])
            begin
                p_lead = bbs_pkg::LOGP_W'(b);
            end
        end
    end

    assign norm = {x, 30'b0} >> p_lead;
    assign sq   = m_reg * m_reg;
    assign sq_s = sq[2*bbs_pkg::MANT_W-1:bbs_pkg::MANT_W-1];
    assign rnd  = {1'b0, prod_reg} + (PROD_W+1)'(64'h8000_0000);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_RND)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg    <= p_lead;
            m_reg    <= norm[bbs_pkg::MANT_W-1:0];
            frac_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg < STEP_MUL)
            begin
                m_reg    <= sq_s[bbs_pkg::MANT_W] ? sq_s[bbs_pkg::MANT_W:1]
                                                   : sq_s[bbs_pkg::MANT_W-1:0];
                frac_reg <= {frac_reg[bbs_pkg::FRAC_BITS-2:0], sq_s[bbs_pkg::MANT_W]};
            end
            else if (step_reg == STEP_MUL)
            begin
                prod_reg <= {p_reg, frac_reg} * bbs_pkg::LN2_Q32;
            end
            else
            begin
                ln_reg <= rnd[32 +: bbs_pkg::LN_W];
            end
        end
    end

    assign done = done_reg;
    assign ln   = ln_reg;
endmodule
`default_nettype wire

FILE: hdl/bbs_dp.sv
// Datapath: event store, dynamic program arithmetic, traceback and output register.
`default_nettype none
module bbs_dp
#(
    parameter int MAX_EVENTS = bbs_pkg::MAX_EVENTS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bbs_pkg::bbs_cmd_t           cmd,
    output bbs_pkg::bbs_stat_t               stat,
    input  wire logic [bbs_pkg::TIME_W-1:0]  event_time,
    input  wire logic                        last_event,
    input  wire logic [bbs_pkg::PEN_W-1:0]   penalty,
    output logic [bbs_pkg::EDGE_W-1:0]       edge_value,
    output logic                             last_edge
);
    localparam int CW = $clog2(MAX_EVENTS + 1);
    localparam int AW = $clog2(MAX_EVENTS);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_EVENTS);
    localparam int FW = bbs_pkg::FIT_W;
    localparam int TERM_W = bbs_pkg::LN_W + 1 + CW + 1;
    localparam int SUM_W = FW + 2;
    localparam int WW = bbs_pkg::EDGE_W + 1;
    localparam logic signed [FW-1:0] FIT_MAX = {1'b0, {(FW-1){1'b1}}};
    localparam logic signed [FW-1:0] FIT_MIN = {1'b1, {(FW-1){1'b0}}};

    logic [bbs_pkg::TIME_W-1:0] ev_mem [MAX_EVENTS];
    logic [FW-1:0]              bf_mem [MAX_EVENTS];
    logic [CW-1:0]              bs_mem [MAX_EVENTS];
    logic [CW-1:0]              tp_mem [MAX_EVENTS+1];

    logic [CW-1:0]                 cnt_reg;
    logic [CW-1:0]                 n_reg, k_reg, i_reg, tp_ptr_reg, ind_reg, e_reg;
    logic [CW-1:0]                 bs_rd_reg, tp_rd_reg, arg_reg;
    logic [bbs_pkg::TIME_W-1:0]    rda_reg, rdb_reg;
    logic signed [bbs_pkg::EDGE_W-1:0] top_reg;
    logic signed [WW-1:0]          w_reg;
    logic [FW-1:0]                 bf_rd_reg;
    logic [bbs_pkg::LN_W-1:0]      ln2c_reg;
    logic signed [TERM_W-1:0]      term_reg;
    logic signed [FW-1:0]          fit_reg, best_reg;
    logic [bbs_pkg::EDGE_W-1:0]    edge_out_reg;
    logic                          last_out_reg;

    logic [CW-1:0]                 j_sel, adr_a, adr_b, n_m1, cnt_pair, i_m1, ind_m1;
    logic signed [bbs_pkg::EDGE_W-1:0] edg;
    logic                          store_ok, rd_en, w_pos;
    logic [bbs_pkg::LOGX_W-1:0]    log_x;
    logic                          log_done;
    logic [bbs_pkg::LN_W-1:0]      log_ln;
    logic signed [bbs_pkg::LN_W:0] diff;
    logic signed [SUM_W-1:0]       sum;

    assign n_m1     = n_reg - 1'b1;
    assign i_m1     = i_reg - 1'b1;
    assign ind_m1   = ind_reg - 1'b1;
    assign cnt_pair = k_reg - i_reg + 1'b1;
    assign store_ok = cnt_reg < MAX_C;
    assign rd_en    = cmd.kread | cmd.iread | cmd.em_ed;
    assign edg      = $signed({rda_reg[bbs_pkg::TIME_W-1], rda_reg})
                    + $signed({rdb_reg[bbs_pkg::TIME_W-1], rdb_reg});
    assign w_pos    = !w_reg[WW-1] && (w_reg != '0);
    assign log_x    = cmd.log_w ? bbs_pkg::LOGX_W'(w_reg)
                                : bbs_pkg::LOGX_W'({cnt_pair, 1'b0});
    assign diff     = $signed({1'b0, ln2c_reg}) - $signed({1'b0, log_ln});
    assign sum      = SUM_W'(term_reg) - $signed({{(SUM_W-bbs_pkg::PEN_W){1'b0}}, penalty})
                    + ((i_reg == '0) ? '0 : SUM_W'($signed(bf_rd_reg)));

    always_comb
    begin
        priority if (cmd.kread)
        begin
            j_sel = k_reg + 1'b1;
        end
        else if (cmd.iread)
        begin
            j_sel = i_reg;
        end
        else
        begin
            j_sel = tp_rd_reg;
        end
        if (j_sel >= n_reg)
        begin
            adr_a = n_m1;
            adr_b = n_m1;
        end
        else if (j_sel == '0)
        begin
            adr_a = '0;
            adr_b = '0;
        end
        else
        begin
            adr_a = j_sel;
            adr_b = j_sel - 1'b1;
        end
    end

    bbs_log u_log
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.log_start),
        .x     (log_x),
        .done  (log_done),
        .ln    (log_ln)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (last_event)
            begin
                cnt_reg <= '0;
            end
            else if (store_ok)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
        begin
            ev_mem[cnt_reg[AW-1:0]] <= event_time;
        end
        if (rd_en)
        begin
            rda_reg <= ev_mem[adr_a[AW-1:0]];
            rdb_reg <= ev_mem[adr_b[AW-1:0]];
        end
        if (cmd.iread)
        begin
            bf_rd_reg <= bf_mem[i_m1[AW-1:0]];
        end
        if (cmd.kwr)
        begin
            bf_mem[k_reg[AW-1:0]] <= best_reg;
            bs_mem[k_reg[AW-1:0]] <= arg_reg;
        end
        if (cmd.tb_wr)
        begin
            tp_mem[tp_ptr_reg] <= ind_reg;
            bs_rd_reg          <= bs_mem[ind_m1[AW-1:0]];
        end
        if (cmd.em_tp)
        begin
            tp_rd_reg <= tp_mem[e_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && last_event)
        begin
            n_reg <= cnt_reg + CW'(store_ok);
            k_reg <= '0;
        end
        if (cmd.ktop)
        begin
            top_reg <= edg;
            i_reg   <= '0;
        end
        if (cmd.wlatch)
        begin
            w_reg <= WW'(top_reg) - WW'(edg);
        end
        if (cmd.ln2c_latch)
        begin
            ln2c_reg <= log_ln;
        end
        if (cmd.term)
        begin
            term_reg <= diff * $signed({1'b0, cnt_pair});
        end
        if (cmd.fit)
        begin
            priority if (!w_pos)
            begin
                fit_reg <= FIT_MAX;
            end
            else if (sum > SUM_W'(FIT_MAX))
            begin
                fit_reg <= FIT_MAX;
            end
            else if (sum < SUM_W'(FIT_MIN))
            begin
                fit_reg <= FIT_MIN;
            end
            else
            begin
                fit_reg <= sum[FW-1:0];
            end
        end
        if (cmd.cmp)
        begin
            if (i_reg == '0 || fit_reg > best_reg)
            begin
                best_reg <= fit_reg;
                arg_reg  <= i_reg;
            end
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.kwr)
        begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.tb_init)
        begin
            tp_ptr_reg <= MAX_C;
            ind_reg    <= n_reg;
        end
        if (cmd.tb_wr)
        begin
            if (stat.tb_done)
            begin
                e_reg <= tp_ptr_reg;
            end
            else
            begin
                tp_ptr_reg <= tp_ptr_reg - 1'b1;
            end
        end
        if (cmd.tb_load)
        begin
            ind_reg <= bs_rd_reg;
        end
        if (cmd.out_load)
        begin
            edge_out_reg <= edg;
            last_out_reg <= (e_reg == MAX_C);
            e_reg        <= e_reg + 1'b1;
        end
    end

    assign stat.k_last   = (k_reg == n_m1);
    assign stat.i_last   = (i_reg == k_reg);
    assign stat.log_done = log_done;
    assign stat.tb_done  = (ind_reg == '0) || (tp_ptr_reg == '0);
    assign stat.em_last  = (e_reg == MAX_C);

    assign edge_value = edge_out_reg;
    assign last_edge  = last_out_reg;
endmodule
`default_nettype wire

FILE: hdl/bbs_ctrl.sv
// Controller state machine sequencing load, dynamic program, traceback and output.
`default_nettype none
module bbs_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tlast,
    output logic                    s_tready,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output bbs_pkg::bbs_cmd_t       cmd,
    input  wire bbs_pkg::bbs_stat_t stat
);
    typedef enum logic [4:0]
    {
        S_LOAD, S_KRD, S_KTOP, S_IRD, S_IW, S_LA_GO, S_LA_WT, S_LB_GO, S_LB_WT,
        S_TERM, S_FIT, S_CMP, S_KWR, S_TBI, S_TBW, S_TBR, S_ETP, S_EED, S_EOUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_LOAD:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = S_KRD;
                    end
                end
            end
            S_KRD:
            begin
                cmd.kread  = 1'b1;
                state_next = S_KTOP;
            end
            S_KTOP:
            begin
                cmd.ktop   = 1'b1;
                state_next = S_IRD;
            end
            S_IRD:
            begin
                cmd.iread  = 1'b1;
                state_next = S_IW;
            end
            S_IW:
            begin
                cmd.wlatch = 1'b1;
                state_next = S_LA_GO;
            end
            S_LA_GO:
            begin
                cmd.log_start = 1'b1;
                state_next    = S_LA_WT;
            end
            S_LA_WT:
            begin
                if (stat.log_done)
                begin
                    cmd.ln2c_latch = 1'b1;
                    state_next     = S_LB_GO;
                end
            end
            S_LB_GO:
            begin
                cmd.log_start = 1'b1;
                cmd.log_w     = 1'b1;
                state_next    = S_LB_WT;
            end
            S_LB_WT:
            begin
                if (stat.log_done)
                begin
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = S_FIT;
            end
            S_FIT:
            begin
                cmd.fit    = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = stat.i_last ? S_KWR : S_IRD;
            end
            S_KWR:
            begin
                cmd.kwr    = 1'b1;
                state_next = stat.k_last ? S_TBI : S_KRD;
            end
            S_TBI:
            begin
                cmd.tb_init = 1'b1;
                state_next  = S_TBW;
            end
            S_TBW:
            begin
                cmd.tb_wr  = 1'b1;
                state_next = stat.tb_done ? S_ETP : S_TBR;
            end
            S_TBR:
            begin
                cmd.tb_load = 1'b1;
                state_next  = S_TBW;
            end
            S_ETP:
            begin
                cmd.em_tp  = 1'b1;
                state_next = S_EED;
            end
            S_EED:
            begin
                cmd.em_ed  = 1'b1;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = stat.em_last ? S_LOAD : S_ETP;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = out_valid_reg;
endmodule
`default_nettype wire

FILE: hdl/bayesian_blocks_segmenter_unit.sv
// Top level of the Bayesian Blocks event segmenter.
//
//  channel | dir | beat contents
//  s_*     | in  | tdata[31:0] event_time, tlast last_event
//  m_*     | out | tdata[32:0] edge_value, tlast last_edge
//  APB     | cfg | 0x0 change_point_penalty [23:0]
//
// Events load at one beat per cycle; the last beat starts the solve.
// Each (k, i) pair is bound by the shared log unit, which computes two logs
// in turn, plus the per-k states KRD, KTOP and KWR; traceback takes states TBW
// and TBR per edge, output ETP, EED and EOUT. Input stalls during solve and output.
// Reset clears the event count, penalty (4.0) and control state.
`default_nettype none
module bayesian_blocks_segmenter_unit
#(
    parameter int MAX_EVENTS = bbs_pkg::MAX_EVENTS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bbs_pkg::IN_TDATA_W-1:0]   s_tdata,   // [31:0] event_time
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [bbs_pkg::OUT_TDATA_W-1:0]       m_tdata,   // [32:0] edge_value, zero pad
    output logic                                  m_tlast,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bbs_pkg::APB_AW-1:0]       paddr,
    input  wire logic [bbs_pkg::APB_DW-1:0]       pwdata,
    output logic [bbs_pkg::APB_DW-1:0]            prdata,
    output logic                                  pready
);
    logic [bbs_pkg::PEN_W-1:0]  pen_reg;
    logic [bbs_pkg::EDGE_W-1:0] edge_value;
    bbs_pkg::bbs_cmd_t          cmd;
    bbs_pkg::bbs_stat_t         stat;
    logic                       pen_sel;

    assign pready  = 1'b1;
    assign pen_sel = (paddr[bbs_pkg::APB_AW-1] == bbs_pkg::ADDR_PENALTY[bbs_pkg::APB_AW-1]);
    assign prdata  = pen_sel ? bbs_pkg::APB_DW'(pen_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg <= bbs_pkg::PEN_RESET;
        end
        else if (psel && penable && pwrite && pready && pen_sel)
        begin
            pen_reg <= pwdata[bbs_pkg::PEN_W-1:0];
        end
    end

    bbs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd),
        .stat     (stat)
    );

    bbs_dp #(.MAX_EVENTS(MAX_EVENTS)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .event_time (s_tdata),
        .last_event (s_tlast),
        .penalty    (pen_reg),
        .edge_value (edge_value),
        .last_edge  (m_tlast)
    );

    assign m_tdata = bbs_pkg::OUT_TDATA_W'(edge_value);
endmodule
`default_nettype wire

FILE: hdl/bbs_chk.sv
// Port-level assertion checker for the segmenter, bound to the top level.
`default_nettype none
module bbs_chk
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        pready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_solve: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken after last event");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open during edge output");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");
endmodule

bind bayesian_blocks_segmenter_unit bbs_chk u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
`default_nettype wire
